// ===== design/bump_allocator_with_reset_top_assert.svh =====
// Assertion macros for the bump allocator checker.
// Needs clk and rst_n in the scope of the file that includes it.
`ifndef BUMP_ALLOCATOR_WITH_RESET_TOP_ASSERT_SVH
`define BUMP_ALLOCATOR_WITH_RESET_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define BAL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bal_pkg.sv =====
// Shared types and constants for the bump allocator.
// No dependencies; every other design file but the assertion macro header uses it.
package bal_pkg;

  localparam int unsigned REQ_W       = 32;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned OUT_OFF_W   = 25;
  // Padding never exceeds the largest alignment minus one.
  localparam int unsigned PAD_W       = 12;
  localparam int unsigned APB_ADDR_W  = 2;

  localparam int unsigned CAPACITY_DEFAULT = 16777216;
  localparam int unsigned ALIGN_DEFAULT    = 16;

  localparam logic [ADDR_W-1:0]     BASE_RESET    = 32'h00E0_0000;
  localparam logic [APB_ADDR_W-1:0] REG_BASE_ADDR = 2'd0;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_RESET = 2'd2
  } bal_op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNINIT   = 3'd1,
    ST_NOT_LIVE = 3'd2,
    ST_NO_ROOM  = 3'd3,
    ST_CROSSES  = 3'd4
  } bal_status_t;

  // Request after the alignment front end.
  typedef struct packed {
    bal_op_t          opcode;
    logic [REQ_W-1:0] want;
    logic             ram_ok;
    logic [PAD_W-1:0] pad;
  } bal_item_t;

  typedef struct packed {
    bal_status_t          status;
    logic [ADDR_W-1:0]    granted_address;
    logic [OUT_OFF_W-1:0] bytes_used;
    logic [OUT_OFF_W-1:0] peak_used;
    logic [CNT_W-1:0]     refusal_count;
    logic [CNT_W-1:0]     reset_count;
    logic [OUT_OFF_W-1:0] bytes_available;
  } bal_result_t;

endpackage

// ===== design/bal_in_if.sv =====
// Request channel of the bump allocator.
// Widths come from bal_pkg.
interface bal_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [bal_pkg::REQ_W-1:0]    request_bytes;
  logic                         ram_ok;

  modport source (output valid, output opcode, output request_bytes, output ram_ok,
                  input ready);
  modport sink   (input valid, input opcode, input request_bytes, input ram_ok,
                  output ready);
endinterface

// ===== design/bal_out_if.sv =====
// Result channel of the bump allocator.
// Widths come from bal_pkg.
interface bal_out_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [bal_pkg::ADDR_W-1:0]    granted_address;
  logic [bal_pkg::OUT_OFF_W-1:0] bytes_used;
  logic [bal_pkg::OUT_OFF_W-1:0] peak_used;
  logic [bal_pkg::CNT_W-1:0]     refusal_count;
  logic [bal_pkg::CNT_W-1:0]     reset_count;
  logic [bal_pkg::OUT_OFF_W-1:0] bytes_available;

  modport source (output valid, output status, output granted_address, output bytes_used,
                  output peak_used, output refusal_count, output reset_count,
                  output bytes_available, input ready);
  modport sink   (input valid, input status, input granted_address, input bytes_used,
                  input peak_used, input refusal_count, input reset_count,
                  input bytes_available, output ready);
endinterface

// ===== design/bal_cfg.sv =====
// APB-style register block holding the arena base address.
// Depends on bal_pkg.
module bal_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bal_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [bal_pkg::ADDR_W-1:0]     base_o
);

  logic [bal_pkg::ADDR_W-1:0] base_r;
  logic                       wr_en;

  // A write completes in the access phase; the port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == bal_pkg::REG_BASE_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= bal_pkg::BASE_RESET;
    end else if (wr_en) begin
      base_r <= pwdata;
    end
  end

  // Read-back of the single register; other addresses read as zero.
  assign prdata = (paddr == bal_pkg::REG_BASE_ADDR) ? base_r : 32'd0;
  assign base_o = base_r;

endmodule

// ===== design/bal_align.sv =====
// Alignment front end: works out the padding that follows each request.
// Two registered stages (reciprocal multiply, then remainder). Depends on bal_pkg.
module bal_align #(
  parameter int unsigned ALIGN_BYTES = bal_pkg::ALIGN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  bal_in_if.sink             in_chan,
  output bal_pkg::bal_item_t item_o,
  output logic               item_valid_o,
  input  logic               item_ready_i
);

  // floor(x / ALIGN) is taken as (x * RECIP) >> SHIFT, at most one too small.
  localparam int unsigned SHIFT   = bal_pkg::REQ_W + $clog2(ALIGN_BYTES);
  localparam logic [63:0] RECIP64 = (64'd1 << SHIFT) / 64'(ALIGN_BYTES);
  localparam logic [32:0] RECIP   = RECIP64[32:0];
  localparam logic [bal_pkg::REQ_W-1:0] ALIGN_C = bal_pkg::REQ_W'(ALIGN_BYTES);

  logic                        a_valid_r, b_valid_r;
  bal_pkg::bal_item_t          a_item_r, b_item_r;
  logic [bal_pkg::REQ_W-1:0]   b_quot_r;
  logic                        a_go, b_go, in_take;
  logic [bal_pkg::REQ_W-1:0]   want_in;
  logic [64:0]                 prod;
  logic [bal_pkg::REQ_W-1:0]   quot;
  logic [bal_pkg::REQ_W-1:0]   rem_raw, rem;

  // Bubble-collapsing handshake through both stages.
  assign b_go          = b_valid_r && item_ready_i;
  assign a_go          = a_valid_r && (!b_valid_r || b_go);
  assign in_chan.ready = !a_valid_r || a_go;
  assign in_take       = in_chan.valid && in_chan.ready;

  // A zero-byte request is taken as one byte.
  assign want_in = (in_chan.request_bytes == '0) ? bal_pkg::REQ_W'(1) : in_chan.request_bytes;

  // Stage A: quotient estimate.
  assign prod = 65'(a_item_r.want) * 65'(RECIP);
  assign quot = bal_pkg::REQ_W'(prod >> SHIFT);

  // Stage B: remainder with one correction, then padding to the next boundary.
  assign rem_raw = b_item_r.want - bal_pkg::REQ_W'(b_quot_r * ALIGN_C);
  assign rem     = (rem_raw >= ALIGN_C) ? (rem_raw - ALIGN_C) : rem_raw;

  always_comb begin
    item_o     = b_item_r;
    item_o.pad = (rem == '0) ? '0 : bal_pkg::PAD_W'(ALIGN_C - rem);
  end
  assign item_valid_o = b_valid_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        a_valid_r <= in_chan.valid;
      end
      if (!b_valid_r || b_go) begin
        b_valid_r <= a_go;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_take) begin
      a_item_r.opcode <= bal_pkg::bal_op_t'(in_chan.opcode);
      a_item_r.want   <= want_in;
      a_item_r.ram_ok <= in_chan.ram_ok;
      a_item_r.pad    <= '0;
    end
    if (a_go) begin
      b_item_r <= a_item_r;
      b_quot_r <= quot;
    end
  end

endmodule

// ===== design/bal_core.sv =====
// Allocator state and result register: one operation per cycle while the result channel is not stalled.
// Depends on bal_pkg and bal_out_if.
module bal_core #(
  parameter int unsigned CAPACITY_BYTES = bal_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bal_pkg::bal_item_t         item_i,
  input  logic                       item_valid_i,
  output logic                       item_ready_o,
  input  logic [bal_pkg::ADDR_W-1:0] base_i,
  bal_out_if.source                  out_chan
);

  localparam int unsigned OFFW = $clog2(CAPACITY_BYTES + 1);
  localparam int unsigned SUMW = ((OFFW > bal_pkg::PAD_W) ? OFFW : bal_pkg::PAD_W) + 1;
  localparam int unsigned EXTW = OFFW + bal_pkg::OUT_OFF_W;
  localparam logic [OFFW-1:0] CAP_OFF = OFFW'(CAPACITY_BYTES);
  localparam logic [SUMW-1:0] CAP_SUM = SUMW'(CAPACITY_BYTES);
  localparam logic [bal_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic                       s_valid_r, o_valid_r;
  bal_pkg::bal_item_t         s_item_r;
  bal_pkg::bal_result_t       o_res_r;
  logic                       core_go;

  logic [OFFW-1:0]            used_r, used_nxt, peak_r, peak_nxt;
  logic [bal_pkg::PAD_W-1:0]  pad_r, pad_nxt;
  logic [bal_pkg::CNT_W-1:0]  refusal_r, refusal_nxt, resets_r, resets_nxt;
  logic                       live_r, live_nxt, init_r, init_nxt;

  logic [SUMW-1:0]            start, room;
  logic [32:0]                end_off;
  bal_pkg::bal_status_t       status;
  logic [bal_pkg::ADDR_W-1:0] granted;
  logic [OFFW-1:0]            avail_nxt;
  logic [EXTW-1:0]            used_ext, peak_ext, avail_ext;

  // Input register frees up as soon as its item moves into the result register.
  assign core_go      = s_valid_r && (!o_valid_r || out_chan.ready);
  assign item_ready_o = !s_valid_r || core_go;

  // Aligned start of the next grant, the room above it and the end of the request.
  assign start   = SUMW'(used_r) + SUMW'(pad_r);
  assign room    = CAP_SUM - start;
  assign end_off = 33'(start) + 33'(s_item_r.want);

  // Operation decode and state update.
  always_comb begin
    used_nxt    = used_r;
    peak_nxt    = peak_r;
    pad_nxt     = pad_r;
    refusal_nxt = refusal_r;
    resets_nxt  = resets_r;
    live_nxt    = live_r;
    init_nxt    = init_r;
    status      = bal_pkg::ST_OK;
    granted     = '0;
    unique case (s_item_r.opcode)
      bal_pkg::OP_INIT: begin
        init_nxt    = 1'b1;
        used_nxt    = '0;
        peak_nxt    = '0;
        pad_nxt     = '0;
        refusal_nxt = '0;
        resets_nxt  = '0;
        live_nxt    = s_item_r.ram_ok;
        status      = s_item_r.ram_ok ? bal_pkg::ST_OK : bal_pkg::ST_NOT_LIVE;
      end
      bal_pkg::OP_ALLOC: begin
        priority if (!init_r) begin
          status = bal_pkg::ST_UNINIT;
        end else if (!live_r) begin
          status = bal_pkg::ST_NOT_LIVE;
        end else if (start > CAP_SUM) begin
          status = bal_pkg::ST_NO_ROOM;
        end else if (s_item_r.want > bal_pkg::REQ_W'(room)) begin
          status = bal_pkg::ST_CROSSES;
        end else begin
          status = bal_pkg::ST_OK;
        end
        if (status != bal_pkg::ST_OK) begin
          refusal_nxt = (refusal_r == CNT_MAX) ? CNT_MAX : refusal_r + 1'b1;
        end else begin
          used_nxt = OFFW'(end_off);
          pad_nxt  = s_item_r.pad;
          if (OFFW'(end_off) > peak_r) begin
            peak_nxt = OFFW'(end_off);
          end
          granted = base_i + bal_pkg::ADDR_W'(start);
        end
      end
      bal_pkg::OP_RESET: begin
        used_nxt    = '0;
        pad_nxt     = '0;
        refusal_nxt = '0;
        resets_nxt  = (resets_r == CNT_MAX) ? CNT_MAX : resets_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Byte fields (used, peak, available) are reported modulo 2^25; the refusal and reset counts saturate.
  assign avail_nxt = live_nxt ? (CAP_OFF - used_nxt) : '0;
  assign used_ext  = EXTW'(used_nxt);
  assign peak_ext  = EXTW'(peak_nxt);
  assign avail_ext = EXTW'(avail_nxt);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
      used_r    <= '0;
      peak_r    <= '0;
      pad_r     <= '0;
      refusal_r <= '0;
      resets_r  <= '0;
      live_r    <= 1'b0;
      init_r    <= 1'b0;
    end else begin
      if (item_ready_o) begin
        s_valid_r <= item_valid_i;
      end
      if (core_go) begin
        o_valid_r <= 1'b1;
        used_r    <= used_nxt;
        peak_r    <= peak_nxt;
        pad_r     <= pad_nxt;
        refusal_r <= refusal_nxt;
        resets_r  <= resets_nxt;
        live_r    <= live_nxt;
        init_r    <= init_nxt;
      end else if (out_chan.ready) begin
        o_valid_r <= 1'b0;
      end
    end
  end

  // Input and result payload registers.
  always_ff @(posedge clk) begin
    if (item_ready_o && item_valid_i) begin
      s_item_r <= item_i;
    end
    if (core_go) begin
      o_res_r.status          <= status;
      o_res_r.granted_address <= granted;
      o_res_r.bytes_used      <= used_ext[bal_pkg::OUT_OFF_W-1:0];
      o_res_r.peak_used       <= peak_ext[bal_pkg::OUT_OFF_W-1:0];
      o_res_r.refusal_count   <= refusal_nxt;
      o_res_r.reset_count     <= resets_nxt;
      o_res_r.bytes_available <= avail_ext[bal_pkg::OUT_OFF_W-1:0];
    end
  end

  assign out_chan.valid           = o_valid_r;
  assign out_chan.status          = o_res_r.status;
  assign out_chan.granted_address = o_res_r.granted_address;
  assign out_chan.bytes_used      = o_res_r.bytes_used;
  assign out_chan.peak_used       = o_res_r.peak_used;
  assign out_chan.refusal_count   = o_res_r.refusal_count;
  assign out_chan.reset_count     = o_res_r.reset_count;
  assign out_chan.bytes_available = o_res_r.bytes_available;

endmodule

// ===== design/bump_allocator_with_reset_top.sv =====
// Channel    Direction  Content
// in_chan    in         opcode, request_bytes, ram_ok
// out_chan   out        status, address, usage, counters, bytes left
// APB        in/out     register 0: base_address at byte address 0
//
// One operation per cycle is accepted while the result channel is not stalled; its
// result passes through the two-stage alignment front end (reciprocal multiply, then
// remainder), the state stage and the result register before it is presented.
// Reset is synchronous and active low; it empties the pipeline, clears the allocator
// state and counters and loads the base register with its reset value.
// A stalled result holds its stage; earlier stages keep filling until they meet it.
// Top level of the bump allocator; depends on bal_pkg, the channel interfaces,
// bal_cfg, bal_align and bal_core.
module bump_allocator_with_reset_top #(
  parameter int unsigned CAPACITY_BYTES = bal_pkg::CAPACITY_DEFAULT,
  parameter int unsigned ALIGN_BYTES    = bal_pkg::ALIGN_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  bal_in_if.sink                         in_chan,
  bal_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bal_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic [bal_pkg::ADDR_W-1:0] base;
  bal_pkg::bal_item_t         item;
  logic                       item_valid, item_ready;

  // Configuration register.
  bal_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base_o  (base)
  );

  // Padding computation ahead of the state stage.
  bal_align #(
    .ALIGN_BYTES (ALIGN_BYTES)
  ) u_align (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Allocator state and result register.
  bal_core #(
    .CAPACITY_BYTES (CAPACITY_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .base_i       (base),
    .out_chan     (out_chan)
  );

endmodule

// ===== design/bal_checker.sv =====
// Port-level checks on the bump allocator, bound to the top level.
// Depends on bal_pkg and the assertion macro header.
`include "bump_allocator_with_reset_top_assert.svh"

module bal_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [2:0]                     out_status,
  input logic [bal_pkg::ADDR_W-1:0]     out_granted,
  input logic [bal_pkg::CNT_W-1:0]      out_refusals,
  input logic [bal_pkg::OUT_OFF_W-1:0]  out_used,
  input logic                           psel,
  input logic                           penable,
  input logic                           pwrite,
  input logic [bal_pkg::APB_ADDR_W-1:0] paddr,
  input logic [31:0]                    pwdata,
  input logic [31:0]                    prdata
);

  logic                 out_stall;
  logic                 out_failed;
  logic                 out_refused;
  logic                 base_sel;
  logic                 base_write;
  logic [91:0]          out_payload;

  // Conditions shared by the checks below.
  assign out_stall   = out_valid && !out_ready;
  assign out_failed  = out_valid && (out_status != bal_pkg::ST_OK);
  assign out_refused = out_valid && ((out_status == bal_pkg::ST_UNINIT) ||
                                     (out_status == bal_pkg::ST_NO_ROOM) ||
                                     (out_status == bal_pkg::ST_CROSSES));
  assign base_sel    = (paddr == bal_pkg::REG_BASE_ADDR);
  assign base_write  = psel && penable && pwrite && base_sel;
  assign out_payload = {out_status, out_granted, out_used, out_refusals};

  // A result that is not taken stays on the port with its status, address, usage and refusal count unchanged.
  `BAL_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_payload), "result not held")

  // Only a granted allocation carries an address.
  `BAL_ASSERT_NOW(a_addr_on_grant, out_failed, out_granted == '0, "address with a refusal")

  // A refused allocation (uninitialised, no room or crossing the end) is always counted.
  `BAL_ASSERT_NOW(a_refusal_counted, out_refused, out_refusals != '0, "refusal not counted")

  // A transfer to the base register reads back once the register has taken it.
  `BAL_ASSERT_NEXT(a_base_readback, base_write, !base_sel || prdata == $past(pwdata), "stale read")

endmodule

bind bump_allocator_with_reset_top bal_props u_bal_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_status   (out_chan.status),
  .out_granted  (out_chan.granted_address),
  .out_refusals (out_chan.refusal_count),
  .out_used     (out_chan.bytes_used),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
